FILE: sv/ptc_pkg.sv
// Shared types and constants of the pressure and temperature compensation block.
// Depends on nothing; every other file refers to it by scoped names.
package ptc_pkg;

  localparam int unsigned RAW_W    = 20;
  localparam int unsigned CAL_W    = 16;
  localparam int unsigned TC_W     = 16;
  localparam int unsigned FINE_W   = 20;
  localparam int unsigned PRESS_W  = 25;
  localparam int unsigned ADDR_W   = 6;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned NUM_W    = 58;
  localparam int unsigned NMAG_W   = 70;
  localparam int unsigned DIV_W    = 34;
  localparam int unsigned QUO_W    = 37;
  localparam int unsigned P_W      = 38;

  typedef enum logic [2:0] {
    REG_T1   = 3'd0,
    REG_T2   = 3'd1,
    REG_T3   = 3'd2,
    REG_P1   = 3'd3,
    REG_P2   = 3'd4,
    REG_P3   = 3'd5,
    REG_P456 = 3'd6,
    REG_P789 = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic        [CAL_W-1:0] t1;
    logic signed [CAL_W-1:0] t2;
    logic signed [CAL_W-1:0] t3;
    logic        [CAL_W-1:0] p1;
    logic signed [CAL_W-1:0] p2;
    logic signed [CAL_W-1:0] p3;
    logic signed [CAL_W-1:0] p4;
    logic signed [CAL_W-1:0] p5;
    logic signed [CAL_W-1:0] p6;
    logic signed [CAL_W-1:0] p7;
    logic signed [CAL_W-1:0] p8;
    logic signed [CAL_W-1:0] p9;
  } cal_t;

  typedef struct packed {
    logic signed [TC_W-1:0]   temp_centi;
    logic signed [FINE_W-1:0] fine_temp;
  } temp_t;

  typedef struct packed {
    temp_t              temp;
    logic [NMAG_W-1:0]  num_mag;
    logic [DIV_W-1:0]   div_mag;
    logic               neg;
    logic               div_zero;
  } job_t;

endpackage

FILE: sv/ptc_if.sv
// Valid/ready channel interfaces for readings in and compensated results out.
// Depends on ptc_pkg for field widths.
interface ptc_in_if;
  logic                       valid;
  logic                       ready;
  logic [ptc_pkg::RAW_W-1:0]  raw_temp;
  logic [ptc_pkg::RAW_W-1:0]  raw_press;

  modport source (output valid, raw_temp, raw_press, input ready);
  modport sink   (input valid, raw_temp, raw_press, output ready);
endinterface

interface ptc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [ptc_pkg::TC_W-1:0]    temp_centi;
  logic signed [ptc_pkg::FINE_W-1:0]  fine_temp;
  logic [ptc_pkg::PRESS_W-1:0]        press_q8;
  logic                               result_status;

  modport source (output valid, temp_centi, fine_temp, press_q8, result_status, input ready);
  modport sink   (input valid, temp_centi, fine_temp, press_q8, result_status, output ready);
endinterface

FILE: sv/ptc_front.sv
// Front pipeline: accepts reading pairs, computes fine temperature, the pressure
// numerator and divisor, and flags a zero divisor. Depends on ptc_pkg.
module ptc_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ptc_pkg::cal_t              cal_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [ptc_pkg::RAW_W-1:0]  raw_temp_i,
  input  logic [ptc_pkg::RAW_W-1:0]  raw_press_i,
  output logic                       job_valid_o,
  input  logic                       job_ready_i,
  output ptc_pkg::job_t              job_o
);

  localparam int unsigned NStages = 9;
  localparam logic signed [24:0] FineMax = 25'sd524287;
  localparam logic signed [24:0] FineMin = -25'sd524288;
  localparam logic signed [51:0] BaseBias = 52'sh0_8000_0000_0000;

  logic                       adv;
  logic [NStages-1:0]         valid_q;

  logic signed [17:0]         diff;
  logic signed [16:0]         dt;
  logic signed [33:0]         tlin_q, tlin_d;
  logic signed [33:0]         dtsq_q, dtsq_d;
  logic [ptc_pkg::RAW_W-1:0]  adcp_q [6];

  logic signed [22:0]         ta_q, ta_d;
  logic signed [37:0]         tb_q, tb_d;

  logic signed [24:0]         fsum;
  logic signed [19:0]         fine_d;
  logic signed [19:0]         fine_q [6];

  logic signed [20:0]         v;
  logic signed [41:0]         vv_q, vv_d;
  logic signed [36:0]         vp5_q, vp5_d, vp5b_q;
  logic signed [36:0]         vp2_q, vp2_d, vp2b_q;

  logic signed [57:0]         vvp6_q, vvp6_d;
  logic signed [57:0]         vvp3_q, vvp3_d;

  logic signed [57:0]         w_q, w_d;
  logic signed [51:0]         base_q, base_d;

  logic [20:0]                n;
  logic signed [68:0]         prod_q, prod_d;
  logic signed [ptc_pkg::NUM_W-1:0] num_q, num_d;

  logic signed [ptc_pkg::DIV_W-1:0] d;
  logic [ptc_pkg::DIV_W-1:0]  div_mag_q, div_mag_d;
  logic                       div_zero_q, div_zero_d;
  logic [ptc_pkg::NUM_W-1:0]  num_mag_q, num_mag_d;
  logic                       neg_q, neg_d;

  logic signed [22:0]         tcx;
  ptc_pkg::job_t              job_q, job_d;

  assign adv         = job_ready_i;
  assign in_ready_o  = adv;
  assign job_valid_o = valid_q[NStages-1];
  assign job_o       = job_q;

  always_comb begin
    diff   = $signed({1'b0, raw_temp_i[19:3]}) - $signed({1'b0, cal_i.t1, 1'b0});
    dt     = $signed({1'b0, raw_temp_i[19:4]}) - $signed({1'b0, cal_i.t1});
    tlin_d = diff * $signed(cal_i.t2);
    dtsq_d = dt * dt;

    ta_d = $signed(tlin_q[33:11]);
    tb_d = $signed(dtsq_q[33:12]) * $signed(cal_i.t3);

    fsum = $signed({{2{ta_q[22]}}, ta_q}) + $signed({tb_q[37], tb_q[37:14]});
    if (fsum > FineMax) begin
      fine_d = FineMax[19:0];
    end else if (fsum < FineMin) begin
      fine_d = FineMin[19:0];
    end else begin
      fine_d = fsum[19:0];
    end

    v     = $signed({fine_q[0][19], fine_q[0]}) - 21'sd128000;
    vv_d  = v * v;
    vp5_d = v * $signed(cal_i.p5);
    vp2_d = v * $signed(cal_i.p2);

    vvp6_d = vv_q * $signed(cal_i.p6);
    vvp3_d = vv_q * $signed(cal_i.p3);

    w_d = vvp6_q + $signed({{4{vp5b_q[36]}}, vp5b_q, 17'd0})
        + $signed({{7{cal_i.p4[15]}}, cal_i.p4, 35'd0});
    base_d = $signed({{2{vvp3_q[57]}}, vvp3_q[57:8]})
           + $signed({{3{vp2b_q[36]}}, vp2b_q, 12'd0}) + BaseBias;

    n      = 21'h10_0000 - {1'b0, adcp_q[5]};
    prod_d = base_q * $signed({1'b0, cal_i.p1});
    num_d  = $signed({6'd0, n, 31'd0}) - w_q;

    d          = $signed(prod_q[66:33]);
    div_zero_d = (d == '0);
    div_mag_d  = d[ptc_pkg::DIV_W-1] ? (~d + 1'b1) : d;
    num_mag_d  = num_q[ptc_pkg::NUM_W-1] ? (~num_q + 1'b1) : num_q;
    neg_d      = num_q[ptc_pkg::NUM_W-1] ^ d[ptc_pkg::DIV_W-1];

    tcx = $signed({{3{fine_q[5][19]}}, fine_q[5]}) * 23'sd5 + 23'sd128;
    job_d.temp.temp_centi = $signed({tcx[22], tcx[22:8]});
    job_d.temp.fine_temp  = fine_q[5];
    job_d.num_mag  = {12'd0, num_mag_q} * 70'd3125;
    job_d.div_mag  = div_mag_q;
    job_d.neg      = neg_q;
    job_d.div_zero = div_zero_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[NStages-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tlin_q    <= tlin_d;
      dtsq_q    <= dtsq_d;
      adcp_q[0] <= raw_press_i;
      for (int k = 1; k < 6; k++) begin
        adcp_q[k] <= adcp_q[k-1];
      end
      ta_q      <= ta_d;
      tb_q      <= tb_d;
      fine_q[0] <= fine_d;
      for (int k = 1; k < 6; k++) begin
        fine_q[k] <= fine_q[k-1];
      end
      vv_q       <= vv_d;
      vp5_q      <= vp5_d;
      vp2_q      <= vp2_d;
      vvp6_q     <= vvp6_d;
      vvp3_q     <= vvp3_d;
      vp5b_q     <= vp5_q;
      vp2b_q     <= vp2_q;
      w_q        <= w_d;
      base_q     <= base_d;
      prod_q     <= prod_d;
      num_q      <= num_d;
      div_mag_q  <= div_mag_d;
      div_zero_q <= div_zero_d;
      num_mag_q  <= num_mag_d;
      neg_q      <= neg_d;
      job_q      <= job_d;
    end
  end

endmodule

FILE: sv/ptc_fifo.sv
// Short queue of front results between the front and back pipelines.
// Depends on ptc_pkg for the entry type.
module ptc_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  ptc_pkg::job_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output ptc_pkg::job_t pop_data_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  ptc_pkg::job_t   mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

FILE: sv/ptc_back.sv
// Back pipeline: one quotient bit per stage, pressure polynomial, saturation
// and the output register. Depends on ptc_pkg.
module ptc_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ptc_pkg::cal_t                 cal_i,
  input  logic                          job_valid_i,
  output logic                          job_ready_o,
  input  ptc_pkg::job_t                 job_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ptc_pkg::temp_t                out_temp_o,
  output logic [ptc_pkg::PRESS_W-1:0]   out_press_o,
  output logic                          out_status_o
);

  localparam int unsigned QW = ptc_pkg::QUO_W;
  localparam int unsigned DW = ptc_pkg::DIV_W;
  localparam int unsigned NBack = QW + 4;
  localparam logic [QW-1:0] PLim = QW'(64'd1 << (QW - 1));
  localparam logic signed [34:0] PressMax = 35'sd33554431;

  typedef struct packed {
    ptc_pkg::temp_t temp;
    logic           div_zero;
    logic           neg;
    logic           ovf;
    logic [DW-1:0]  dv;
    logic [QW-1:0]  low;
    logic [DW-1:0]  rem;
    logic [QW-1:0]  quo;
  } div_st_t;

  logic               adv;
  logic [NBack-1:0]   bvalid_q;
  logic               out_valid_q;

  div_st_t            load_d;
  div_st_t            st_q [QW+1];
  div_st_t            st_d [1:QW];

  logic [QW-1:0]      mag;
  logic signed [ptc_pkg::P_W-1:0] pa_p_q, pa_p_d, pb_p_q, pc_p_q;
  ptc_pkg::temp_t     pa_t_q, pb_t_q, pc_t_q;
  logic               pa_z_q, pb_z_q, pc_z_q;

  logic signed [24:0] p13;
  logic signed [49:0] sq_q, sq_d;
  logic signed [53:0] p8p_q, p8p_d, pc_p8p_q;
  logic signed [65:0] sq9_q, sq9_d;

  logic signed [41:0] psum;
  logic signed [34:0] pfin;
  logic [ptc_pkg::PRESS_W-1:0] press_d, press_q;
  ptc_pkg::temp_t     temp_q;
  logic               status_q;

  assign adv          = !out_valid_q || out_ready_i;
  assign job_ready_o  = adv;
  assign out_valid_o  = out_valid_q;
  assign out_temp_o   = temp_q;
  assign out_press_o  = press_q;
  assign out_status_o = status_q;

  always_comb begin
    load_d.temp     = job_i.temp;
    load_d.div_zero = job_i.div_zero;
    load_d.neg      = job_i.neg;
    load_d.ovf      = ({1'b0, job_i.num_mag[69:37]} >= job_i.div_mag);
    load_d.dv       = job_i.div_mag;
    load_d.low      = job_i.num_mag[QW-1:0];
    load_d.rem      = {1'b0, job_i.num_mag[69:37]};
    load_d.quo      = '0;
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [DW:0] shifted;
    logic        ge;
    always_comb begin
      shifted = {st_q[k].rem, st_q[k].low[QW-1-k]};
      ge      = (shifted >= {1'b0, st_q[k].dv});
      st_d[k+1] = st_q[k];
      st_d[k+1].rem = ge ? DW'(shifted - {1'b0, st_q[k].dv}) : shifted[DW-1:0];
      st_d[k+1].quo[QW-1-k] = ge;
    end
  end

  always_comb begin
    mag    = (st_q[QW].ovf || st_q[QW].quo > PLim) ? PLim : st_q[QW].quo;
    pa_p_d = st_q[QW].neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

    p13   = $signed(pa_p_q[37:13]);
    sq_d  = p13 * p13;
    p8p_d = pa_p_q * $signed(cal_i.p8);

    sq9_d = sq_q * $signed(cal_i.p9);

    psum = $signed({{4{pc_p_q[37]}}, pc_p_q}) + $signed({sq9_q[65], sq9_q[65:25]})
         + $signed({{7{pc_p8p_q[53]}}, pc_p8p_q[53:19]});
    pfin = $signed({psum[41], psum[41:8]}) + $signed({{15{cal_i.p7[15]}}, cal_i.p7, 4'd0});
    if (pc_z_q || pfin < 35'sd0) begin
      press_d = '0;
    end else if (pfin > PressMax) begin
      press_d = PressMax[ptc_pkg::PRESS_W-1:0];
    end else begin
      press_d = pfin[ptc_pkg::PRESS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvalid_q    <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      bvalid_q    <= {bvalid_q[NBack-2:0], job_valid_i};
      out_valid_q <= bvalid_q[NBack-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q[0] <= load_d;
      for (int k = 1; k <= QW; k++) begin
        st_q[k] <= st_d[k];
      end
      pa_p_q   <= pa_p_d;
      pa_t_q   <= st_q[QW].temp;
      pa_z_q   <= st_q[QW].div_zero;
      sq_q     <= sq_d;
      p8p_q    <= p8p_d;
      pb_p_q   <= pa_p_q;
      pb_t_q   <= pa_t_q;
      pb_z_q   <= pa_z_q;
      sq9_q    <= sq9_d;
      pc_p8p_q <= p8p_q;
      pc_p_q   <= pb_p_q;
      pc_t_q   <= pb_t_q;
      pc_z_q   <= pb_z_q;
      press_q  <= press_d;
      temp_q   <= pc_t_q;
      status_q <= pc_z_q;
    end
  end

endmodule

FILE: sv/pressure_temperature_compensation.sv
// Pressure and temperature compensation top level: calibration registers and pipelines.
// Throughput: one item per cycle without back-pressure; the 37-stage quotient pipeline makes up most of the latency.
// Reset clears calibration words to zero and empties every pipeline and the queue.
// Depends on ptc_pkg, ptc_if, ptc_front, ptc_fifo and ptc_back.
module pressure_temperature_compensation #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ptc_in_if.sink                        in_i,
  ptc_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ptc_pkg::ADDR_W-1:0]    paddr,
  input  logic [ptc_pkg::DATA_W-1:0]    pwdata,
  output logic [ptc_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  ptc_pkg::cal_t     cal_q, cal_d;
  ptc_pkg::reg_idx_e cfg_idx;
  logic              cfg_we;

  logic              fr_valid, fr_ready;
  ptc_pkg::job_t     fr_job;
  logic              bk_valid, bk_ready;
  ptc_pkg::job_t     bk_job;
  ptc_pkg::temp_t    out_temp;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign cfg_idx = ptc_pkg::reg_idx_e'(paddr[ptc_pkg::ADDR_W-1:3]);

  always_comb begin
    cal_d = cal_q;
    unique case (cfg_idx)
      ptc_pkg::REG_T1: cal_d.t1 = pwdata[15:0];
      ptc_pkg::REG_T2: cal_d.t2 = pwdata[15:0];
      ptc_pkg::REG_T3: cal_d.t3 = pwdata[15:0];
      ptc_pkg::REG_P1: cal_d.p1 = pwdata[15:0];
      ptc_pkg::REG_P2: cal_d.p2 = pwdata[15:0];
      ptc_pkg::REG_P3: cal_d.p3 = pwdata[15:0];
      ptc_pkg::REG_P456: begin
        cal_d.p4 = pwdata[15:0];
        cal_d.p5 = pwdata[31:16];
        cal_d.p6 = pwdata[47:32];
      end
      ptc_pkg::REG_P789: begin
        cal_d.p7 = pwdata[15:0];
        cal_d.p8 = pwdata[31:16];
        cal_d.p9 = pwdata[47:32];
      end
    endcase
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      ptc_pkg::REG_T1:   prdata[15:0] = cal_q.t1;
      ptc_pkg::REG_T2:   prdata[15:0] = cal_q.t2;
      ptc_pkg::REG_T3:   prdata[15:0] = cal_q.t3;
      ptc_pkg::REG_P1:   prdata[15:0] = cal_q.p1;
      ptc_pkg::REG_P2:   prdata[15:0] = cal_q.p2;
      ptc_pkg::REG_P3:   prdata[15:0] = cal_q.p3;
      ptc_pkg::REG_P456: prdata[47:0] = {cal_q.p6, cal_q.p5, cal_q.p4};
      ptc_pkg::REG_P789: prdata[47:0] = {cal_q.p9, cal_q.p8, cal_q.p7};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else if (cfg_we) begin
      cal_q <= cal_d;
    end
  end

  ptc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cal_i       (cal_q),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .raw_temp_i  (in_i.raw_temp),
    .raw_press_i (in_i.raw_press),
    .job_valid_o (fr_valid),
    .job_ready_i (fr_ready),
    .job_o       (fr_job)
  );

  ptc_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_job),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_job)
  );

  ptc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cal_i        (cal_q),
    .job_valid_i  (bk_valid),
    .job_ready_o  (bk_ready),
    .job_i        (bk_job),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_temp_o   (out_temp),
    .out_press_o  (out_o.press_q8),
    .out_status_o (out_o.result_status)
  );

  assign out_o.temp_centi = out_temp.temp_centi;
  assign out_o.fine_temp  = out_temp.fine_temp;

`ifndef SYNTH
  a_zero_div_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.result_status |-> out_o.press_q8 == '0)
    else $error("zero divisor result carries nonzero pressure");

  a_t1_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we && cfg_idx == ptc_pkg::REG_T1 |=> cal_q.t1 == $past(pwdata[15:0]))
    else $error("temperature word one not written");

  a_p789_pack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we && cfg_idx == ptc_pkg::REG_P789 |=>
      cal_q.p7 == $past(pwdata[15:0]) && cal_q.p9 == $past(pwdata[47:32]))
    else $error("packed pressure words seven to nine misplaced");
`endif

endmodule
